// File: src/msre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msre_pkg
// shared constants, types and the cell visit-order mapping of the sprite
// rectangle expander
// ----------------------------------------------------------------------------
package msre_pkg;

  localparam int CellsPerSide    = 8;
  localparam int LastCell        = 7;
  localparam int NumCells        = CellsPerSide * CellsPerSide;
  localparam int CellIdxW        = $clog2(NumCells);
  localparam int ColW            = $clog2(CellsPerSide);
  localparam int DefaultMaxScale = 16;
  localparam int ScaleW          = 5;
  localparam int CoordInW        = 12;
  localparam int CoordOutW       = 13;
  localparam int ColorW          = 24;

  typedef enum logic [1:0] {
    ORIENT_NORMAL  = 2'd0,
    ORIENT_FLIPPED = 2'd1,
    ORIENT_ROT90   = 2'd2,
    ORIENT_ROT270  = 2'd3
  } orient_t;

  typedef struct packed {
    logic load;
    logic step;
  } shift_ctrl_t;

  typedef struct packed {
    logic cur_bit;
    logic more_set;
  } shift_stat_t;

  // bit k of the result is the sprite bit of the k-th visited cell
  function automatic logic [NumCells-1:0] visit_order(input logic [NumCells-1:0] bits,
                                                      input orient_t o);
    logic [NumCells-1:0] res;
    int idx;
    res = '0;
    for (int r = 0; r < CellsPerSide; r++) begin
      for (int c = 0; c < CellsPerSide; c++) begin
        case (o)
          ORIENT_NORMAL:  idx = (LastCell - r) * CellsPerSide + (LastCell - c);
          ORIENT_FLIPPED: idx = r * CellsPerSide + c;
          ORIENT_ROT90:   idx = (LastCell - c) * CellsPerSide + r;
          ORIENT_ROT270:  idx = c * CellsPerSide + (LastCell - r);
          default:        idx = 0;
        endcase
        res[r * CellsPerSide + c] = bits[idx[CellIdxW-1:0]];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/msre_cell_shifter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msre_cell_shifter
// bitmap shift register in visit order, one cell bit out per step
// ----------------------------------------------------------------------------
module msre_cell_shifter (
  input  logic                              clk,
  input  logic [msre_pkg::NumCells-1:0]     sprite_bits,
  input  msre_pkg::orient_t                 orient,
  input  msre_pkg::shift_ctrl_t             ctrl,
  output msre_pkg::shift_stat_t             stat
);
  import msre_pkg::*;

  logic [NumCells-1:0] cells;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cells <= visit_order(sprite_bits, orient);
    end else if (ctrl.step) begin
      cells <= {1'b0, cells[NumCells-1:1]};
    end
  end

  // current cell sits at bit 0, later cells above it
  assign stat.cur_bit  = cells[0];
  assign stat.more_set = |cells[NumCells-1:1];

endmodule
`default_nettype wire

// File: src/mono_sprite_rect_expander_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_sprite_rect_expander_unit
// expands one 8x8 one-bit sprite into square fill commands
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one sprite per transaction, carrying
//   origin, cell scale, two colours, the 64-bit bitmap, orientation and the
//   see-through flag. in_stall is high while a sprite is being walked.
//   output channel (out_valid / out_stall): one square per transaction, the
//   final square of a sprite flagged by is_last.
//   the cells are visited one per cycle while the receiver does not stall,
//   row by row then column by column, through a 64-bit shift register loaded
//   in visit order; a walk covers all 64 cells, fewer in see-through mode
//   (the walk ends after the last set cell). once the walk has started, the
//   first square is registered in the output register. an empty sprite in
//   see-through mode is taken and gives no squares. the next sprite is taken
//   in the idle state after the walk ends, while the last square may still
//   sit in the output register.
//   a stalled receiver freezes the walk: the output register holds its
//   square and the cell walker waits until it is free.
//   reset (rst, synchronous) returns to idle and drops any pending square.
// ----------------------------------------------------------------------------
module mono_sprite_rect_expander_unit #(
  parameter int MAX_SCALE = msre_pkg::DefaultMaxScale
) (
  input  logic                                clk,
  input  logic                                rst,
  // sprite input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [msre_pkg::CoordInW-1:0]       origin_x,
  input  logic [msre_pkg::CoordInW-1:0]       origin_y,
  input  logic [msre_pkg::ScaleW-1:0]         cell_scale,
  input  logic [msre_pkg::ColorW-1:0]         fore_color,
  input  logic [msre_pkg::ColorW-1:0]         back_color,
  input  logic [msre_pkg::NumCells-1:0]       sprite_bits,
  input  logic [1:0]                          orient,
  input  logic                                see_through,
  // square output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msre_pkg::CoordOutW-1:0]      rect_x,
  output logic [msre_pkg::CoordOutW-1:0]      rect_y,
  output logic [msre_pkg::ScaleW-1:0]         rect_side,
  output logic [msre_pkg::ColorW-1:0]         rect_color,
  output logic                                is_last
);
  import msre_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CellIdxW-1:0]  cnt;
  logic [CoordInW-1:0]  base_x;
  logic [CoordOutW-1:0] pos_x;
  logic [CoordOutW-1:0] pos_y;
  logic [ScaleW-1:0]    side;
  logic [ColorW-1:0]    fore;
  logic [ColorW-1:0]    back;
  logic                 see;

  logic [ScaleW-1:0]    side_in;
  logic                 in_fire;
  logic                 sprite_empty;
  logic                 step;
  logic                 emit;
  logic                 last_cell;
  logic                 walk_done;
  logic                 row_end;
  shift_ctrl_t          sh_ctrl;
  shift_stat_t          sh_stat;

  // scale of zero acts as one, large scales saturate
  always_comb begin
    if (cell_scale == '0) begin
      side_in = ScaleW'(1);
    end else if (int'(cell_scale) > MAX_SCALE) begin
      side_in = ScaleW'(MAX_SCALE);
    end else begin
      side_in = cell_scale;
    end
  end

  assign in_stall     = (state == ST_WALK);
  assign in_fire      = in_valid && !in_stall;
  assign sprite_empty = see_through && (sprite_bits == '0);

  // walker advances one cell when the output register can take a square
  assign step      = (state == ST_WALK) && (!out_valid || !out_stall);
  assign emit      = sh_stat.cur_bit || !see;
  assign last_cell = (cnt == CellIdxW'(NumCells - 1));
  assign row_end   = (cnt[ColW-1:0] == ColW'(LastCell));
  // see-through walk ends once no set cell is left
  assign walk_done = last_cell || (see && !sh_stat.more_set);

  assign sh_ctrl.load = in_fire;
  assign sh_ctrl.step = step;

  msre_cell_shifter u_shifter (
    .clk         (clk),
    .sprite_bits (sprite_bits),
    .orient      (orient_t'(orient)),
    .ctrl        (sh_ctrl),
    .stat        (sh_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && !sprite_empty) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step && walk_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sprite context and running cell position
  always_ff @(posedge clk) begin
    if (in_fire) begin
      base_x <= origin_x;
      pos_x  <= {1'b0, origin_x};
      pos_y  <= {1'b0, origin_y};
      side   <= side_in;
      fore   <= fore_color;
      back   <= back_color;
      see    <= see_through;
      cnt    <= '0;
    end else if (step) begin
      cnt <= cnt + CellIdxW'(1);
      if (row_end) begin
        pos_x <= {1'b0, base_x};
        pos_y <= pos_y + CoordOutW'(side);
      end else begin
        pos_x <= pos_x + CoordOutW'(side);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rect_x     <= pos_x;
      rect_y     <= pos_y;
      rect_side  <= side;
      rect_color <= sh_stat.cur_bit ? fore : back;
      is_last    <= walk_done;
    end
  end

  // a sprite with something to draw starts a walk
  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    in_fire && !sprite_empty |=> state == ST_WALK)
    else $error("sprite accepted but walk not started");

  // the square flagged last ends the walk
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step && emit && walk_done |=> state == ST_IDLE && out_valid && is_last)
    else $error("last square did not end the walk");

  // no square is produced outside a walk
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    !out_valid && state == ST_IDLE |=> !out_valid)
    else $error("square produced while idle");

  // a waiting square is never overwritten by the walker
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !step)
    else $error("walker advanced over a stalled square");

  a_side_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rect_side != '0)
    else $error("square with zero side");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sprite rectangle expander: each sprite sent in
// is expanded by a local predictor into the expected run of squares, and each
// square that leaves the block is compared field by field with the oldest
// expectation. directed sprites come first, then random ones, with random
// idling on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;

  import msre_pkg::*;

  localparam int          ScaleCap   = DefaultMaxScale;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int          HoldCycles = 300;
  localparam int          TailCycles = 100;

  // one sprite as offered on the input channel
  typedef struct {
    logic [CoordInW-1:0] x;
    logic [CoordInW-1:0] y;
    logic [ScaleW-1:0]   scale;
    logic [ColorW-1:0]   fore;
    logic [ColorW-1:0]   back;
    logic [NumCells-1:0] bits;
    orient_t             orient;
    logic                see;
  } sprite_t;

  // one square fill command as it leaves the block
  typedef struct {
    logic [CoordOutW-1:0] x;
    logic [CoordOutW-1:0] y;
    logic [ScaleW-1:0]    side;
    logic [ColorW-1:0]    color;
    logic                 last;
  } square_t;

  logic clk = 1'b0;
  logic rst;

  logic                 in_valid;
  logic                 in_stall;
  logic [CoordInW-1:0]  origin_x;
  logic [CoordInW-1:0]  origin_y;
  logic [ScaleW-1:0]    cell_scale;
  logic [ColorW-1:0]    fore_color;
  logic [ColorW-1:0]    back_color;
  logic [NumCells-1:0]  sprite_bits;
  logic [1:0]           orient;
  logic                 see_through;
  logic                 out_valid;
  logic                 out_stall;
  logic [CoordOutW-1:0] rect_x;
  logic [CoordOutW-1:0] rect_y;
  logic [ScaleW-1:0]    rect_side;
  logic [ColorW-1:0]    rect_color;
  logic                 is_last;

  square_t     pending_squares[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // idling switches, flipped by the test tasks
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  // long receiver hold-off requests, counted up by the test tasks and
  // picked up by the stall process
  int unsigned hold_req = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mono_sprite_rect_expander_unit #(
    .MAX_SCALE(ScaleCap)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .cell_scale (cell_scale),
    .fore_color (fore_color),
    .back_color (back_color),
    .sprite_bits(sprite_bits),
    .orient     (orient),
    .see_through(see_through),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_side  (rect_side),
    .rect_color (rect_color),
    .is_last    (is_last)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // bitmap index of the cell at column col, row row under orientation o
  function automatic int cell_index(orient_t o, int col, int row);
    case (o)
      ORIENT_NORMAL:  return (LastCell - row) * CellsPerSide + (LastCell - col);
      ORIENT_FLIPPED: return row * CellsPerSide + col;
      ORIENT_ROT90:   return (LastCell - col) * CellsPerSide + row;
      default:        return col * CellsPerSide + (LastCell - row);
    endcase
  endfunction

  // walks the 64 cells and queues the squares that the sprite should give
  function automatic void expand_sprite(sprite_t s);
    int          side;
    int          first_new;
    logic        cell_on;
    square_t     sq;
    side      = int'(s.scale);
    first_new = pending_squares.size();
    // zero scale reads as one, oversize scale clips to the cap
    if (side == 0)
      side = 1;
    if (side > ScaleCap)
      side = ScaleCap;
    for (int row = 0; row < CellsPerSide; row++) begin
      for (int col = 0; col < CellsPerSide; col++) begin
        cell_on = s.bits[cell_index(s.orient, col, row)];
        if (s.see && !cell_on)
          continue;
        sq.x     = CoordOutW'(int'(s.x) + col * side);
        sq.y     = CoordOutW'(int'(s.y) + row * side);
        sq.side  = ScaleW'(side);
        sq.color = cell_on ? s.fore : s.back;
        sq.last  = 1'b0;
        pending_squares.push_back(sq);
      end
    end
    // an empty see-through sprite leaves nothing to flag
    if (pending_squares.size() > first_new)
      pending_squares[pending_squares.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // mostly short, now and then long
  function automatic int unsigned pause_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(16, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned sender_gap();
    if (!tx_idle_en || $urandom_range(0, 2) != 0)
      return 0;
    return pause_len();
  endfunction

  function automatic sprite_t make_sprite(logic [CoordInW-1:0] x, logic [CoordInW-1:0] y,
                                          logic [ScaleW-1:0] scale, logic [ColorW-1:0] fore,
                                          logic [ColorW-1:0] back, logic [NumCells-1:0] bits,
                                          orient_t o, logic see);
    sprite_t s;
    s.x      = x;
    s.y      = y;
    s.scale  = scale;
    s.fore   = fore;
    s.back   = back;
    s.bits   = bits;
    s.orient = o;
    s.see    = see;
    return s;
  endfunction

  function automatic logic [NumCells-1:0] random_bitmap();
    logic [NumCells-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return a & b & c;                        // sparse
      3:       return a | b;                            // dense
      4:       return {{(NumCells-1){1'b0}}, 1'b1} << $urandom_range(0, NumCells - 1);
      default: return a;
    endcase
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.x      = CoordInW'($urandom);
    s.y      = CoordInW'($urandom);
    // mostly legal scales, sometimes zero or beyond the cap
    s.scale  = ($urandom_range(0, 7) == 0) ? ScaleW'($urandom_range(0, 31))
                                           : ScaleW'($urandom_range(1, ScaleCap));
    s.fore   = ColorW'($urandom);
    s.back   = ColorW'($urandom);
    s.bits   = random_bitmap();
    s.orient = orient_t'($urandom_range(0, 3));
    s.see    = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // offers one sprite, waits for the transaction, then idles for the given gap;
  // with no gap valid stays high for the next sprite
  task automatic send_sprite(sprite_t s, int unsigned gap);
    in_valid    <= 1'b1;
    origin_x    <= s.x;
    origin_y    <= s.y;
    cell_scale  <= s.scale;
    fore_color  <= s.fore;
    back_color  <= s.back;
    sprite_bits <= s.bits;
    orient      <= s.orient;
    see_through <= s.see;
    do
      @(posedge clk);
    while (in_stall);
    expand_sprite(s);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender goes quiet until every queued square has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_squares.size() > 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------

  task automatic test_field_extremes();
    send_sprite(make_sprite('1, '1, ScaleW'(ScaleCap), '1, '0, '1, ORIENT_NORMAL, 1'b0),
                sender_gap());
    send_sprite(make_sprite('0, '0, 5'd1, '0, '1, '0, ORIENT_NORMAL, 1'b0), sender_gap());
    send_sprite(make_sprite(12'hAAA, 12'h555, 5'd16, 24'hA5A5A5, 24'h5A5A5A,
                            64'hAAAA_AAAA_AAAA_AAAA, ORIENT_FLIPPED, 1'b0), sender_gap());
    send_sprite(make_sprite(12'h555, 12'hAAA, 5'd15, 24'h5A5A5A, 24'hA5A5A5,
                            64'h5555_5555_5555_5555, ORIENT_ROT90, 1'b1), sender_gap());
  endtask

  // an asymmetric bitmap painted and a two-corner bitmap see-through, through every orientation
  task automatic test_orientations();
    orient_t o;
    for (int k = 0; k < 4; k++) begin
      o = orient_t'(k);
      send_sprite(make_sprite(12'd100, 12'd200, 5'd3, 24'h00FF00, 24'h0000FF,
                              64'h0123_4567_89AB_CDEF, o, 1'b0), sender_gap());
      send_sprite(make_sprite(12'd7, 12'd9, 5'd2, 24'hFF0000, 24'h00FFFF,
                              64'h8000_0000_0000_0001, o, 1'b1), sender_gap());
    end
  endtask

  // zero scale behaves as one; anything above the cap clips
  task automatic test_scale_limits();
    send_sprite(make_sprite(12'd10, 12'd20, 5'd0, 24'h123456, 24'h654321,
                            64'hF0F0_0F0F_F0F0_0F0F, ORIENT_NORMAL, 1'b0), sender_gap());
    send_sprite(make_sprite('1, '1, 5'd31, 24'hFFFFFF, 24'h000000,
                            64'hFFFF_0000_FFFF_0000, ORIENT_ROT270, 1'b0), sender_gap());
    send_sprite(make_sprite(12'd4000, 12'd4000, 5'd17, 24'h0F0F0F, 24'hF0F0F0,
                            64'h00FF_00FF_00FF_00FF, ORIENT_FLIPPED, 1'b1), sender_gap());
    send_sprite(make_sprite(12'd0, 12'd4095, 5'd1, 24'h111111, 24'h222222,
                            64'hDEAD_BEEF_CAFE_F00D, ORIENT_ROT90, 1'b0), sender_gap());
  endtask

  // see-through sprites with nothing set give no squares at all; one- and all-set ones mixed in
  task automatic test_empty_see_through();
    send_sprite(make_sprite(12'd50, 12'd60, 5'd4, 24'hABCDEF, 24'hFEDCBA,
                            '0, ORIENT_NORMAL, 1'b1), sender_gap());
    send_sprite(make_sprite(12'd51, 12'd61, 5'd4, 24'hABCDEF, 24'hFEDCBA,
                            64'h0000_0000_0000_0080, ORIENT_NORMAL, 1'b1), sender_gap());
    send_sprite(make_sprite(12'd52, 12'd62, 5'd8, 24'h000001, 24'h800000,
                            '0, ORIENT_ROT270, 1'b1), 0);
    send_sprite(make_sprite(12'd53, 12'd63, 5'd8, 24'h000001, 24'h800000,
                            '0, ORIENT_ROT90, 1'b1), sender_gap());
    send_sprite(make_sprite(12'd54, 12'd64, 5'd2, 24'h7FFFFF, 24'h000000,
                            '1, ORIENT_FLIPPED, 1'b1), sender_gap());
  endtask

  // receiver holds off for a long stretch while sprites keep coming, so the
  // block fills and stalls its input; then the sender waits for a full drain and sends three more
  task automatic test_backpressure();
    hold_req++;
    for (int k = 0; k < 6; k++)
      send_sprite(random_sprite(), 0);
    wait_for_drain();
    for (int k = 0; k < 3; k++)
      send_sprite(random_sprite(), sender_gap());
  endtask

  // back to back with no idling first, then idling on both sides
  task automatic test_random_sprites(int unsigned n_sprites);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int unsigned k = 0; k < n_sprites; k++) begin
      if (k == n_sprites / 4) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      send_sprite(random_sprite(), sender_gap());
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver stall process
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_out_stall
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    if (rst) begin
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = hold_req;
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 99) < 15) begin
        stall_left = pause_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // square checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_squares
    square_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_squares.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected square: x=%0d y=%0d side=%0d color=%h last=%b",
                   rect_x, rect_y, rect_side, rect_color, is_last);
      end else begin
        want = pending_squares.pop_front();
        if (rect_x !== want.x || rect_y !== want.y || rect_side !== want.side ||
            rect_color !== want.color || is_last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("square mismatch: expected x=%0d y=%0d side=%0d color=%h last=%b",
                     want.x, want.y, want.side, want.color, want.last);
            $display("                 got      x=%0d y=%0d side=%0d color=%h last=%b",
                     rect_x, rect_y, rect_side, rect_color, is_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    origin_x    <= '0;
    origin_y    <= '0;
    cell_scale  <= '0;
    fore_color  <= '0;
    back_color  <= '0;
    sprite_bits <= '0;
    orient      <= ORIENT_NORMAL;
    see_through <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_orientations();
    test_scale_limits();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_empty_see_through();
    test_backpressure();
    test_random_sprites(100);

    // let the last squares out, then watch for strays
    wait_for_drain();
    repeat (TailCycles) @(posedge clk);

    if (mismatch_cnt == 0 && pending_squares.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/msre_pkg.sv
src/msre_cell_shifter.sv
src/mono_sprite_rect_expander_unit.sv
dv/tb_top.sv
